// ===== src/lpwe_pkg.sv =====
// shared types and constants of the lsb position watermark embedder
package lpwe_pkg;

  localparam int unsigned MAX_HOP_DEF = 4096;
  localparam int unsigned MARK_BITS   = 96;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned WORD_COUNT  = 3;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned PCM_W       = 16;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned HOP_LEN_W   = 13;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [GAIN_W-1:0]    GAIN_RESET    = 16'd256;
  localparam logic [HOP_LEN_W-1:0] HOP_LEN_RESET = 13'd512;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN       = 1'b0,
    REG_HOP_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       source_present;
    logic [WORD_BITS-1:0]       pos_x;
    logic [WORD_BITS-1:0]       pos_y;
    logic [WORD_BITS-1:0]       pos_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] sample_out;
    logic                    hop_last;
  } out_beat_t;

  // per-sample decisions made by the hop controller
  typedef struct packed {
    logic has_source;
    logic mark_en;
    logic mark_bit;
    logic hop_last;
  } ctrl_t;

endpackage

// ===== src/lsb_position_watermark_embed.sv =====
// top level of the lsb position watermark embedder: config, stage registers, handshake
//
//  channel  direction  signals                          beat
//  in       input      in_valid / in_ready / in_beat    one 24-bit sample, flag, 3 words
//  out      output     out_valid / out_ready / out_beat one 16-bit pcm sample, hop_last
//  cfg      input      cfg_we / cfg_index / cfg_data    one register write, no wait
//
// one beat in and one beat out per cycle while the output is not stalled; each beat passes
// two register stages, the first stage and the result register, and is offered once it
// reaches the result register. the first stage holds the counter decisions, the second the scaled,
// rounded and marked sample (one multiply).
// reset clears the counter, latched words, valid flags and registers to their defaults.
// a stalled output holds its beat and back-pressure reaches in_ready in the same cycle.
module lsb_position_watermark_embed #(
  parameter int unsigned MAX_HOP = lpwe_pkg::MAX_HOP_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  lpwe_pkg::in_beat_t                    in_beat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output lpwe_pkg::out_beat_t                   out_beat,
  input  logic                                  cfg_we,
  input  logic [lpwe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lpwe_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [lpwe_pkg::GAIN_W-1:0]          gain;
  logic [lpwe_pkg::HOP_LEN_W-1:0]       hop_length;

  logic                                 accept;
  lpwe_pkg::ctrl_t                      ctrl;

  logic                                 s1_valid;
  logic signed [lpwe_pkg::SAMPLE_W-1:0] s1_sample;
  lpwe_pkg::ctrl_t                      s1_ctrl;
  logic                                 s1_advance;
  logic signed [lpwe_pkg::PCM_W-1:0]    pcm;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain       <= lpwe_pkg::GAIN_RESET;
      hop_length <= lpwe_pkg::HOP_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpwe_pkg::REG_GAIN:       gain       <= cfg_data[lpwe_pkg::GAIN_W-1:0];
        lpwe_pkg::REG_HOP_LENGTH: hop_length <= cfg_data[lpwe_pkg::HOP_LEN_W-1:0];
        default:                  ;
      endcase
    end
  end

  // pipeline flow control
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  lpwe_hop_ctrl #(
    .MAX_HOP (MAX_HOP)
  ) u_hop_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .hop_length (hop_length),
    .in_beat    (in_beat),
    .ctrl       (ctrl)
  );

  // first stage: sample and per-sample decisions
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= in_beat.sample_in;
      s1_ctrl   <= ctrl;
    end
  end

  lpwe_pcm_scale u_pcm_scale (
    .sample (s1_sample),
    .gain   (gain),
    .ctrl   (s1_ctrl),
    .pcm    (pcm)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_beat.sample_out <= pcm;
      out_beat.hop_last   <= s1_ctrl.hop_last;
    end
  end

  // no beat is taken while both stages are full and the output stalls
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is full");

  // a first-stage beat moves on as soon as the output frees
  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance |=> out_valid)
    else $error("first stage beat lost");

  // an accepted beat is held in the first stage next cycle
  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat not captured");

endmodule

// ===== src/lpwe_hop_ctrl.sv =====
// hop position counter, latched position words and watermark bit selection
module lpwe_hop_ctrl #(
  parameter int unsigned MAX_HOP = lpwe_pkg::MAX_HOP_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [lpwe_pkg::HOP_LEN_W-1:0]     hop_length,
  input  lpwe_pkg::in_beat_t                 in_beat,
  output lpwe_pkg::ctrl_t                    ctrl
);

  localparam int unsigned IDX_W = $clog2(MAX_HOP);
  localparam int unsigned CNT_W = $clog2(MAX_HOP + 1);
  localparam int unsigned N_W   = (CNT_W > lpwe_pkg::HOP_LEN_W) ? CNT_W : lpwe_pkg::HOP_LEN_W;
  localparam logic [N_W-1:0] N_MIN = N_W'(lpwe_pkg::MARK_BITS);
  localparam logic [N_W-1:0] N_MAX = N_W'(MAX_HOP);
  localparam logic [IDX_W-1:0] MARK_END = IDX_W'(lpwe_pkg::MARK_BITS);

  logic [IDX_W-1:0]                   sample_index;
  logic [IDX_W-1:0]                   sample_index_next;
  logic [lpwe_pkg::WORD_BITS-1:0]     position_words [lpwe_pkg::WORD_COUNT];
  logic                               hop_has_source;

  logic                               hop_start;
  logic [N_W-1:0]                     hop_len_ext;
  logic [N_W-1:0]                     hop_n;
  logic [N_W-1:0]                     idx_plus_one;
  logic [lpwe_pkg::WORD_BITS-1:0]     cur_word;
  logic                               cur_source;

  assign hop_start = (sample_index == '0);

  // hop length clamped to the range the counter supports
  always_comb begin
    hop_len_ext = N_W'(hop_length);
    if (hop_len_ext < N_MIN) begin
      hop_n = N_MIN;
    end else if (hop_len_ext > N_MAX) begin
      hop_n = N_MAX;
    end else begin
      hop_n = hop_len_ext;
    end
  end

  assign idx_plus_one = N_W'(sample_index) + N_W'(1);

  // position word for this sample, fresh from the beat at hop start
  always_comb begin
    cur_source = hop_start ? in_beat.source_present : hop_has_source;
    unique case (sample_index[6:5])
      2'd0:    cur_word = hop_start ? in_beat.pos_x : position_words[0];
      2'd1:    cur_word = hop_start ? in_beat.pos_y : position_words[1];
      default: cur_word = hop_start ? in_beat.pos_z : position_words[2];
    endcase
  end

  always_comb begin
    ctrl.has_source = cur_source;
    ctrl.mark_en    = (sample_index < MARK_END);
    ctrl.mark_bit   = cur_word[sample_index[4:0]];
    ctrl.hop_last   = (idx_plus_one >= hop_n);
    sample_index_next = ctrl.hop_last ? '0 : idx_plus_one[IDX_W-1:0];
  end

  // counter and hop-start latches
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index      <= '0;
      hop_has_source    <= 1'b0;
      position_words[0] <= '0;
      position_words[1] <= '0;
      position_words[2] <= '0;
    end else if (accept) begin
      sample_index <= sample_index_next;
      if (hop_start) begin
        hop_has_source    <= in_beat.source_present;
        position_words[0] <= in_beat.pos_x;
        position_words[1] <= in_beat.pos_y;
        position_words[2] <= in_beat.pos_z;
      end
    end
  end

  // counter stays below the maximum hop length
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    N_W'(sample_index) < N_MAX)
    else $error("sample index beyond max hop");

  // last sample of a hop wraps the counter
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && ctrl.hop_last |=> sample_index == '0)
    else $error("counter did not wrap after last sample");

  // other samples step the counter by one
  a_step: assert property (@(posedge clk) disable iff (rst)
    accept && !ctrl.hop_last |=> sample_index == IDX_W'($past(sample_index) + IDX_W'(1)))
    else $error("counter did not advance");

endmodule

// ===== src/lpwe_pcm_scale.sv =====
// gain scaling, half-up rounding, saturation, lsb insertion and muting without a source
module lpwe_pcm_scale (
  input  logic signed [lpwe_pkg::SAMPLE_W-1:0] sample,
  input  logic [lpwe_pkg::GAIN_W-1:0]          gain,
  input  lpwe_pkg::ctrl_t                      ctrl,
  output logic signed [lpwe_pkg::PCM_W-1:0]    pcm
);

  localparam int unsigned PROD_W = lpwe_pkg::SAMPLE_W + lpwe_pkg::GAIN_W + 1;
  localparam int unsigned Q_W    = PROD_W - 16;
  localparam logic signed [Q_W-1:0] PCM_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] PCM_MIN = -Q_W'(32768);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [Q_W-1:0]    q;
  logic signed [lpwe_pkg::PCM_W-1:0] sat;

  // exact product, then floor((p + 2^15) / 2^16)
  assign prod    = PROD_W'(sample) * $signed({1'b0, gain});
  assign rounded = prod + PROD_W'(32768);
  assign q       = rounded[PROD_W-1:16];

  always_comb begin
    if (q > PCM_MAX) begin
      sat = 16'sh7FFF;
    end else if (q < PCM_MIN) begin
      sat = -16'sh8000;
    end else begin
      sat = q[lpwe_pkg::PCM_W-1:0];
    end
    if (!ctrl.has_source) begin
      pcm = '0;
    end else if (ctrl.mark_en) begin
      pcm = {sat[lpwe_pkg::PCM_W-1:1], ctrl.mark_bit};
    end else begin
      pcm = sat;
    end
  end

endmodule
